### hw/rtl/dws_pkg.sv
// Shared types, constants and a helper function for the card shuffler.
`timescale 1ns / 1ps

package dws_pkg;

    // Fixed field widths.
    localparam int WORD_W = 31;
    localparam int CODE_W = 6;
    localparam int SUIT_W = 2;
    localparam int RANK_W = 4;
    localparam int DECK_W = 7;

    // Standard deck layout.
    localparam int SUIT_CARDS = 13;
    localparam int SUIT_COUNT = 4;
    localparam int STD_CARDS  = SUIT_CARDS * SUIT_COUNT;

    // Deck size after reset.
    localparam logic [DECK_W-1:0] DECK_RESET = DECK_W'(STD_CARDS);

    // Cells per first-level group of the pick tree.
    localparam int GROUP_CELLS = 8;

    // Input beat payload.
    typedef struct packed {
        logic [WORD_W-1:0] random_word;
    } draw_beat_t;

    // Output beat payload.
    typedef struct packed {
        logic [CODE_W-1:0] card_code;
        logic [SUIT_W-1:0] suit;
        logic [RANK_W-1:0] rank;
        logic              deck_done;
    } deal_beat_t;

    // Configuration beat payload.
    typedef struct packed {
        logic [DECK_W-1:0] deck_size;
    } cfg_beat_t;

    // Controls broadcast to every cell of the chain.
    typedef struct packed {
        logic shift;
        logic reload;
    } cell_ctrl_t;

    // Suit and rank of one card.
    typedef struct packed {
        logic [SUIT_W-1:0] suit;
        logic [RANK_W-1:0] rank;
    } face_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_REMOVE,
        ST_COLLECT
    } ctrl_state_t;

    // Split a card code into suit and rank; non-standard cards give zeros.
    function automatic face_t card_face(logic [CODE_W-1:0] code);
        face_t f;
        f = '0;
        if (code < CODE_W'(STD_CARDS))
        begin
            for (int s = 0; s < SUIT_COUNT; s++)
            begin
                if (code >= CODE_W'(s * SUIT_CARDS))
                begin
                    f.suit = SUIT_W'(s);
                    f.rank = RANK_W'(code - CODE_W'(s * SUIT_CARDS));
                end
            end
        end
        return f;
    endfunction

endpackage

### hw/rtl/dws_stream_if.sv
// Valid/ready channel interface carrying one payload beat.
`timescale 1ns / 1ps

interface dws_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/draw_without_replacement_shuffler_top.sv
// Top level of the card shuffler: controller, remainder unit and cell chain.
`timescale 1ns / 1ps

// Deals a random permutation of an ordered deck, one card per input beat.
// Channels: draw carries a 31-bit random word, deal returns the card code
// with suit, rank and a last-card flag, cfg writes the deck size (0 acts as
// 1, sizes above MAX_CARDS act as MAX_CARDS) and reloads the deck at once.
// cfg is always ready and must only be written while the block is idle.
// Each draw beat runs a bit-serial remainder (31 steps, then a step in which its
// done flag is seen), a remove step in which every cell at or above the
// chosen position takes its upper neighbor while the chosen card enters a
// registered OR tree, and a collect step.
// A result is registered onto deal by the collect step; a new draw beat is taken
// only once the block is idle again, and the remainder unit takes most of the time
// per item. The output register lets the next item start while a result
// still waits; if it has not been taken when the next card is ready, the
// block holds in the collect step until deal is free.
// Reset loads the ordered deck and a deck size of 52.
// After the last card of a deck the flag is set and the deck is reloaded.
module draw_without_replacement_shuffler_top #(
    parameter int MAX_CARDS = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    dws_stream_if.sink   draw,
    dws_stream_if.source deal,
    dws_stream_if.sink   cfg
);

    localparam int CNT_W       = $clog2(MAX_CARDS + 1);
    localparam int IDX_W       = $clog2(MAX_CARDS);
    localparam int GROUPS      = (MAX_CARDS + dws_pkg::GROUP_CELLS - 1) / dws_pkg::GROUP_CELLS;
    localparam int RESET_COUNT = (dws_pkg::STD_CARDS > MAX_CARDS) ? MAX_CARDS
                                                                   : dws_pkg::STD_CARDS;

    dws_pkg::ctrl_state_t       state_reg, state_next;
    logic [dws_pkg::DECK_W-1:0] deck_size_reg, deck_size_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       out_valid_reg, out_valid_next;
    dws_pkg::deal_beat_t        out_data_reg, out_data_next;
    logic [dws_pkg::CODE_W-1:0] group_reg [GROUPS];
    logic [dws_pkg::CODE_W-1:0] group_next [GROUPS];

    logic                       draw_take;
    logic                       cfg_write;
    logic                       div_done;
    logic [IDX_W-1:0]           pos;
    logic [dws_pkg::DECK_W-1:0] size_src;
    logic [CNT_W-1:0]           eff_size;
    logic                       out_free;
    logic                       commit;
    logic [dws_pkg::CODE_W-1:0] picked;
    dws_pkg::face_t             face;
    dws_pkg::cell_ctrl_t        cell_ctrl;

    logic [dws_pkg::CODE_W-1:0] cards [MAX_CARDS];
    logic [dws_pkg::CODE_W-1:0] picks [MAX_CARDS];

    // Handshakes.
    assign draw.ready = (state_reg == dws_pkg::ST_IDLE);
    assign draw_take  = draw.valid && draw.ready;
    assign cfg.ready  = 1'b1;
    assign cfg_write  = cfg.valid;
    assign out_free   = !out_valid_reg || deal.ready;

    // Effective deck size from the stored or incoming register value.
    always_comb
    begin
        size_src = cfg_write ? cfg.data.deck_size : deck_size_reg;
        if (size_src == '0)
        begin
            eff_size = CNT_W'(1);
        end
        else if (size_src > dws_pkg::DECK_W'(MAX_CARDS))
        begin
            eff_size = CNT_W'(MAX_CARDS);
        end
        else
        begin
            eff_size = size_src[CNT_W-1:0];
        end
    end

    // Remainder unit: position of the card to draw.
    dws_mod_unit #(
        .CNT_W (CNT_W),
        .IDX_W (IDX_W)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (draw_take),
        .word      (draw.data.random_word),
        .divisor   (count_reg),
        .done      (div_done),
        .remainder (pos)
    );

    // Chain of cells; the top cell feeds itself.
    genvar gi;
    generate
        for (gi = 0; gi < MAX_CARDS; gi++)
        begin : g_cell
            if (gi == MAX_CARDS - 1)
            begin : g_top
                dws_cell #(
                    .IDX_W (IDX_W),
                    .INDEX (gi)
                ) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (cell_ctrl),
                    .pos        (pos),
                    .upper_card (cards[gi]),
                    .card       (cards[gi]),
                    .pick       (picks[gi])
                );
            end
            else
            begin : g_mid
                dws_cell #(
                    .IDX_W (IDX_W),
                    .INDEX (gi)
                ) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (cell_ctrl),
                    .pos        (pos),
                    .upper_card (cards[gi + 1]),
                    .card       (cards[gi]),
                    .pick       (picks[gi])
                );
            end
        end
    endgenerate

    // First level of the pick tree: OR of each group of cells.
    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            group_next[g] = '0;
            for (int k = 0; k < dws_pkg::GROUP_CELLS; k++)
            begin
                if (g * dws_pkg::GROUP_CELLS + k < MAX_CARDS)
                begin
                    group_next[g] = group_next[g] | picks[g * dws_pkg::GROUP_CELLS + k];
                end
            end
        end
    end

    // Second level of the pick tree and card decode.
    always_comb
    begin
        picked = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            picked = picked | group_reg[g];
        end
        face = dws_pkg::card_face(picked);
    end

    // Controller: next state, cell controls and output register.
    always_comb
    begin
        state_next     = state_reg;
        deck_size_next = deck_size_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !deal.ready;
        out_data_next  = out_data_reg;
        commit         = 1'b0;
        cell_ctrl      = '0;

        case (state_reg)
            dws_pkg::ST_IDLE:
            begin
                if (draw_take)
                begin
                    state_next = dws_pkg::ST_DIVIDE;
                end
            end
            dws_pkg::ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = dws_pkg::ST_REMOVE;
                end
            end
            dws_pkg::ST_REMOVE:
            begin
                cell_ctrl.shift = 1'b1;
                count_next      = count_reg - 1'b1;
                state_next      = dws_pkg::ST_COLLECT;
            end
            dws_pkg::ST_COLLECT:
            begin
                if (out_free)
                begin
                    commit                  = 1'b1;
                    out_valid_next          = 1'b1;
                    out_data_next.card_code = picked;
                    out_data_next.suit      = face.suit;
                    out_data_next.rank      = face.rank;
                    out_data_next.deck_done = (count_reg == '0);
                    state_next              = dws_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dws_pkg::ST_IDLE;
            end
        endcase

        // Deck reload after the last card or on a size write.
        if (cfg_write)
        begin
            deck_size_next = cfg.data.deck_size;
        end
        if (cfg_write || (commit && (count_reg == '0)))
        begin
            cell_ctrl.reload = 1'b1;
            count_next       = eff_size;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dws_pkg::ST_IDLE;
            deck_size_reg <= dws_pkg::DECK_RESET;
            count_reg     <= CNT_W'(RESET_COUNT);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            deck_size_reg <= deck_size_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (state_reg == dws_pkg::ST_REMOVE)
        begin
            for (int g = 0; g < GROUPS; g++)
            begin
                group_reg[g] <= group_next[g];
            end
        end
    end

    assign deal.valid = out_valid_reg;
    assign deal.data  = out_data_reg;

endmodule

### hw/rtl/dws_mod_unit.sv
// Bit-serial restoring remainder unit: word modulo a small count.
`timescale 1ns / 1ps

module dws_mod_unit #(
    parameter int CNT_W = 7,
    parameter int IDX_W = 6
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [dws_pkg::WORD_W-1:0] word,
    input  logic [CNT_W-1:0]           divisor,
    output logic                       done,
    output logic [IDX_W-1:0]           remainder
);

    localparam int BIT_CNT_W = $clog2(dws_pkg::WORD_W);

    logic                       busy_reg,    busy_next;
    logic                       done_reg,    done_next;
    logic [BIT_CNT_W-1:0]       bit_cnt_reg, bit_cnt_next;
    logic [dws_pkg::WORD_W-1:0] word_reg,    word_next;
    logic [CNT_W:0]             rem_reg,     rem_next;
    logic [CNT_W:0]             rem_shift;

    // One quotient bit per cycle, MSB first.
    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        bit_cnt_next = bit_cnt_reg;
        word_next    = word_reg;
        rem_next     = rem_reg;
        rem_shift    = {rem_reg[CNT_W-1:0], word_reg[dws_pkg::WORD_W-1]};
        if (start)
        begin
            busy_next    = 1'b1;
            bit_cnt_next = '0;
            word_next    = word;
            rem_next     = '0;
        end
        else if (busy_reg)
        begin
            word_next    = {word_reg[dws_pkg::WORD_W-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + 1'b1;
            if (rem_shift >= {1'b0, divisor})
            begin
                rem_next = rem_shift - {1'b0, divisor};
            end
            else
            begin
                rem_next = rem_shift;
            end
            if (bit_cnt_reg == BIT_CNT_W'(dws_pkg::WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            bit_cnt_reg <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            done_reg    <= done_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        rem_reg  <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg[IDX_W-1:0];

endmodule

### hw/rtl/dws_cell.sv
// One position of the remaining-card list; takes its upper neighbor on removal.
`timescale 1ns / 1ps

module dws_cell #(
    parameter int IDX_W = 6,
    parameter int INDEX = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  dws_pkg::cell_ctrl_t        ctrl,
    input  logic [IDX_W-1:0]           pos,
    input  logic [dws_pkg::CODE_W-1:0] upper_card,
    output logic [dws_pkg::CODE_W-1:0] card,
    output logic [dws_pkg::CODE_W-1:0] pick
);

    localparam logic [dws_pkg::CODE_W-1:0] HOME_CODE = dws_pkg::CODE_W'(INDEX);
    localparam logic [IDX_W-1:0]           MY_POS    = IDX_W'(INDEX);

    logic [dws_pkg::CODE_W-1:0] card_reg, card_next;

    // Reload to the ordered code, or close the gap at and above the removed slot.
    always_comb
    begin
        card_next = card_reg;
        if (ctrl.reload)
        begin
            card_next = HOME_CODE;
        end
        else if (ctrl.shift && (MY_POS >= pos))
        begin
            card_next = upper_card;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            card_reg <= HOME_CODE;
        end
        else
        begin
            card_reg <= card_next;
        end
    end

    assign card = card_reg;
    assign pick = (MY_POS == pos) ? card_reg : '0;

endmodule
